// File: rtl/load_store_align_unit_defines.svh
// ----------------------------------------------------------------------------
// load_store_align_unit_defines
// assertion macros shared by the load/store alignment unit
// ----------------------------------------------------------------------------
`ifndef LOAD_STORE_ALIGN_UNIT_DEFINES_SVH
`define LOAD_STORE_ALIGN_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// implication or plain property, sampled on clk, off while in reset
`define LSAU_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// condition that must never hold
`define LSAU_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define LSAU_ASSERT(lbl, prop, msg)
`define LSAU_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

// File: rtl/lsau_pkg.sv
// ----------------------------------------------------------------------------
// lsau_pkg
// types, codes and sizes of the load/store alignment unit
// ----------------------------------------------------------------------------
`default_nettype none

package lsau_pkg;

	localparam int MEM_WORDS = 1024;
	localparam int IDX_W     = $clog2(MEM_WORDS);
	localparam int ADDR_W    = 12;
	localparam int WADDR_W   = ADDR_W - 2;
	localparam int QDEPTH    = 2;
	localparam int QPTR_W    = $clog2(QDEPTH);
	localparam int QCNT_W    = $clog2(QDEPTH + 1);

	localparam logic       MODE_READ  = 1'b0;
	localparam logic       MODE_WRITE = 1'b1;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_HALF = 2'd1;
	localparam logic [1:0] SIZE_WORD = 2'd2;

	localparam logic [1:0] STAT_ALIGNED   = 2'd0;
	localparam logic [1:0] STAT_UNALIGNED = 2'd1;
	localparam logic [1:0] STAT_DROPPED   = 2'd2;

	typedef enum logic [1:0] {
		RD_NONE,
		RD_BYTE,
		RD_HALF,
		RD_WORD
	} rd_sel_t;

	typedef struct packed {
		logic              mode;
		logic [1:0]        size;
		logic [ADDR_W-1:0] address;
		logic [31:0]       write_data;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [1:0]  status;
	} rsp_t;

	// classified access as held in the queue
	typedef struct packed {
		logic             wr;
		rd_sel_t          rsel;
		logic [1:0]       lane;
		logic [IDX_W-1:0] idx0;
		logic [IDX_W-1:0] idx1;
		logic [3:0]       wmask;
		logic [31:0]      wdata;
		logic [1:0]       status;
	} op_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

`default_nettype wire

// File: rtl/lsau_ram.sv
// ----------------------------------------------------------------------------
// lsau_ram
// generic ram, one write port, two registered read ports
// ----------------------------------------------------------------------------
`default_nettype none

module lsau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

`default_nettype wire

// File: rtl/lsau_fifo.sv
// ----------------------------------------------------------------------------
// lsau_fifo
// short queue of classified accesses between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module lsau_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire lsau_pkg::op_t push_op,
	input  wire logic         pop,
	output logic              full,
	output logic              valid,
	output lsau_pkg::op_t     head
);

	lsau_pkg::op_t                     entry_q [lsau_pkg::QDEPTH];
	logic [lsau_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [lsau_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [lsau_pkg::QCNT_W-1:0]       count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full    = count_q == lsau_pkg::QCNT_W'(lsau_pkg::QDEPTH);
	assign valid   = count_q != '0;
	assign head    = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == lsau_pkg::QPTR_W'(lsau_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == lsau_pkg::QPTR_W'(lsau_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/lsau_front.sv
// ----------------------------------------------------------------------------
// lsau_front
// request acceptance and classification into word indexes, lanes and masks
// ----------------------------------------------------------------------------
`default_nettype none

module lsau_front (
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire lsau_pkg::req_t       req,
	input  wire lsau_pkg::back_stat_t stat,
	input  wire logic                 q_full,
	output logic                      push,
	output lsau_pkg::op_t             op
);

	logic [1:0]                    lane;
	logic [lsau_pkg::WADDR_W-1:0]  waddr;
	logic [lsau_pkg::WADDR_W-1:0]  waddr_nxt;

	assign req_ready = !q_full && !stat.clearing;
	assign push      = req_valid && req_ready;

	assign lane      = req.address[1:0];
	assign waddr     = req.address[lsau_pkg::ADDR_W-1:2];
	assign waddr_nxt = waddr + 1'b1;

	always_comb begin
		op        = '0;
		op.rsel   = lsau_pkg::RD_NONE;
		op.lane   = lane;
		op.idx0   = lsau_pkg::IDX_W'(waddr % lsau_pkg::MEM_WORDS);
		op.idx1   = lsau_pkg::IDX_W'(waddr_nxt % lsau_pkg::MEM_WORDS);
		op.status = lsau_pkg::STAT_ALIGNED;
		if (req.mode == lsau_pkg::MODE_READ) begin
			unique case (req.size)
				lsau_pkg::SIZE_BYTE: begin
					op.rsel = lsau_pkg::RD_BYTE;
				end
				lsau_pkg::SIZE_HALF: begin
					op.rsel = lsau_pkg::RD_HALF;
					if (lane[0]) begin
						op.status = lsau_pkg::STAT_UNALIGNED;
					end
				end
				lsau_pkg::SIZE_WORD: begin
					op.rsel = lsau_pkg::RD_WORD;
					if (lane != 2'd0) begin
						op.status = lsau_pkg::STAT_UNALIGNED;
					end
				end
				default: begin
					op.rsel = lsau_pkg::RD_NONE;
				end
			endcase
		end else begin
			unique case (req.size)
				lsau_pkg::SIZE_BYTE: begin
					op.wr    = 1'b1;
					op.wmask = 4'b0001 << lane;
					op.wdata = {4{req.write_data[7:0]}};
				end
				lsau_pkg::SIZE_HALF: begin
					if (lane[0]) begin
						op.status = lsau_pkg::STAT_DROPPED;
					end else begin
						op.wr    = 1'b1;
						op.wmask = lane[1] ? 4'b1100 : 4'b0011;
						op.wdata = {2{req.write_data[15:0]}};
					end
				end
				lsau_pkg::SIZE_WORD: begin
					op.wr    = 1'b1;
					op.wmask = 4'b1111;
					op.wdata = req.write_data;
					if (lane != 2'd0) begin
						op.status = lsau_pkg::STAT_UNALIGNED;
					end
				end
				default: begin
					op.wr = 1'b0;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/lsau_back.sv
// ----------------------------------------------------------------------------
// lsau_back
// memory sequencer: clearing sweep, word reads, lane merge or extract, result
// ----------------------------------------------------------------------------
`default_nettype none

module lsau_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire lsau_pkg::op_t q_head,
	output logic               q_pop,
	output lsau_pkg::back_stat_t stat,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output lsau_pkg::rsp_t     rsp
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_ISSUE,
		ST_MERGE
	} state_t;

	state_t                     state_q;
	logic [lsau_pkg::IDX_W-1:0] clr_q;
	lsau_pkg::op_t              op_s1;
	logic                       rsp_valid_q;
	lsau_pkg::rsp_t             rsp_q;

	logic                       ram_we;
	logic [lsau_pkg::IDX_W-1:0] ram_waddr;
	logic [31:0]                ram_wdata;
	logic [31:0]                word0;
	logic [31:0]                word1;
	logic [63:0]                pair_sh;
	logic [31:0]                rd_val;
	logic [31:0]                merged;
	logic                       fire;

	lsau_ram #(
		.WIDTH (32),
		.DEPTH (lsau_pkg::MEM_WORDS)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (ram_wdata),
		.re      (q_pop),
		.raddr_a (q_head.idx0),
		.raddr_b (q_head.idx1),
		.rdata_a (word0),
		.rdata_b (word1)
	);

	assign q_pop         = (state_q == ST_ISSUE) && q_valid;
	assign fire          = (state_q == ST_MERGE) && (!rsp_valid_q || rsp_ready);
	assign stat.clearing = state_q == ST_CLEAR;

	assign pair_sh = {word1, word0} >> {op_s1.lane, 3'b000};

	always_comb begin
		unique case (op_s1.rsel)
			lsau_pkg::RD_BYTE: rd_val = {24'd0, pair_sh[7:0]};
			lsau_pkg::RD_HALF: rd_val = {16'd0, pair_sh[15:0]};
			lsau_pkg::RD_WORD: rd_val = pair_sh[31:0];
			default:           rd_val = '0;
		endcase
	end

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			merged[b*8 +: 8] = op_s1.wmask[b] ? op_s1.wdata[b*8 +: 8] : word0[b*8 +: 8];
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = fire && op_s1.wr;
			ram_waddr = op_s1.idx0;
			ram_wdata = merged;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			op_s1       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_valid_q && rsp_ready && !fire) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == lsau_pkg::IDX_W'(lsau_pkg::MEM_WORDS - 1)) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (q_valid) begin
						op_s1   <= q_head;
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (fire) begin
						rsp_valid_q     <= 1'b1;
						rsp_q.read_data <= rd_val;
						rsp_q.status    <= op_s1.status;
						state_q         <= ST_ISSUE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

// File: rtl/load_store_align_unit.sv
// path: a taken request is queued; the issue state pops it and reads its
//   words, the merge state writes back or extracts, registers the response,
//   stalled by rsp_ready; the single word memory serves one access at a time
// reset: asynchronous, active low; afterwards the memory is swept to zero,
//   one word per cycle through all 1024 words, while req_ready stays low
// ----------------------------------------------------------------------------
// load_store_align_unit
// byte/halfword/word loads and stores on a little-endian word memory
// ----------------------------------------------------------------------------
`default_nettype none

`include "load_store_align_unit_defines.svh"

module load_store_align_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire lsau_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_ready,
	output lsau_pkg::rsp_t      rsp
);

	lsau_pkg::back_stat_t stat;
	lsau_pkg::op_t        push_op;
	lsau_pkg::op_t        q_head;
	logic                 push;
	logic                 q_full;
	logic                 q_valid;
	logic                 q_pop;

	lsau_front u_front (
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.stat      (stat),
		.q_full    (q_full),
		.push      (push),
		.op        (push_op)
	);

	lsau_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (q_pop),
		.full    (q_full),
		.valid   (q_valid),
		.head    (q_head)
	);

	lsau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`LSAU_ASSERT_NEVER(a_no_req_while_clearing, req_valid && req_ready && stat.clearing, "request taken during memory clear")
	`LSAU_ASSERT(a_queue_empty_after_clear, $fell(stat.clearing) |-> !q_valid, "queue not empty when clear ends")
	`LSAU_ASSERT(a_dropped_reads_zero, (rsp_valid && rsp.status == lsau_pkg::STAT_DROPPED) |-> (rsp.read_data == '0), "dropped write returned data")

endmodule

`default_nettype wire

// File: tb/load_store_align_unit_tb.sv
// ----------------------------------------------------------------------------
// load_store_align_unit_tb
// Drives byte, halfword and word loads and stores, aligned and unaligned, and
// no-access requests into the alignment unit through its request channel. A
// memory image kept in the bench predicts each response. Responses are
// compared field by field, in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module load_store_align_unit_tb;

	import lsau_pkg::*;

	localparam logic [1:0] SIZE_NONE   = 2'd3;
	localparam int         RAND_ITEMS  = 1750;
	localparam int         CYCLE_LIMIT = 200000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	req_t        pending_req[$];
	rsp_t        expected_rsp[$];
	logic [31:0] mem_image [MEM_WORDS];
	logic        req_taken;
	int          cycle_count;
	int          req_count;
	int          rsp_count;
	int          mismatch_count;
	int          read_count;
	int          write_count;
	int          unaligned_count;
	int          dropped_count;
	int          noop_count;
	logic        calm;

	load_store_align_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// no idling while this stretch of transfers goes through
	assign calm = (req_count >= 800) && (req_count < 1100);

	function automatic logic [7:0] byte_at(input logic [ADDR_W-1:0] a);
		logic [31:0] w;
		w = mem_image[a[ADDR_W-1:2]];
		return w[8*a[1:0] +: 8];
	endfunction

	function automatic logic [31:0] bytes_from(input logic [ADDR_W-1:0] a, input int count);
		logic [31:0] v;
		v = '0;
		for (int k = 0; k < count; k++)
			v[8*k +: 8] = byte_at(ADDR_W'(a + k));
		return v;
	endfunction

	function automatic rsp_t predict_access(input req_t r);
		rsp_t             o;
		logic [1:0]       lane;
		logic [IDX_W-1:0] idx;
		logic [31:0]      w;
		o = '0;
		lane = r.address[1:0];
		idx = r.address[ADDR_W-1:2];
		w = mem_image[idx];
		if (r.size == SIZE_NONE) begin
			noop_count++;
		end else if (r.mode == MODE_READ) begin
			read_count++;
			case (r.size)
			SIZE_BYTE: o.read_data = {24'd0, byte_at(r.address)};
			SIZE_HALF: begin
				if (lane[0]) begin
					o.read_data = bytes_from(r.address, 2);
					o.status = STAT_UNALIGNED;
				end else begin
					o.read_data = {16'd0, w[16*lane[1] +: 16]};
				end
			end
			default: begin
				if (lane != 2'd0) begin
					o.read_data = bytes_from(r.address, 4);
					o.status = STAT_UNALIGNED;
				end else begin
					o.read_data = w;
				end
			end
			endcase
		end else begin
			write_count++;
			case (r.size)
			SIZE_BYTE: w[8*lane +: 8] = r.write_data[7:0];
			SIZE_HALF: begin
				if (lane[0])
					o.status = STAT_DROPPED;
				else
					w[16*lane[1] +: 16] = r.write_data[15:0];
			end
			default: begin
				w = r.write_data;
				if (lane != 2'd0)
					o.status = STAT_UNALIGNED;
			end
			endcase
			mem_image[idx] = w;
		end
		if (o.status == STAT_UNALIGNED)
			unaligned_count++;
		if (o.status == STAT_DROPPED)
			dropped_count++;
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
	endtask

	task automatic add_access(input logic mode, input logic [1:0] size,
			input logic [ADDR_W-1:0] address, input logic [31:0] data);
		req_t r;
		r.mode = mode;
		r.size = size;
		r.address = address;
		r.write_data = data;
		pending_req.push_back(r);
	endtask

	// driver
	always @(negedge clk) begin
		req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_ready <= 1'b0;
		end else begin
			if (!req_valid || req_taken) begin
				if (pending_req.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
					nxt = pending_req.pop_front();
					req <= nxt;
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_ready <= calm || ($urandom_range(99) >= 10);
		end
	end

	// monitor
	always @(posedge clk) begin
		rsp_t want;
		req_taken <= req_valid && req_ready;
		if (arst_n) begin
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("end of test: mismatches");
				$finish;
			end else begin
				if (req_valid && req_ready) begin
					expected_rsp.push_back(predict_access(req));
					req_count++;
				end
				if (rsp_valid && rsp_ready) begin
					rsp_count++;
					if (expected_rsp.size() == 0) begin
						report_mismatch("unexpected transfer", rsp.read_data, '0);
					end else begin
						want = expected_rsp.pop_front();
						if (rsp.read_data !== want.read_data)
							report_mismatch("read_data", rsp.read_data, want.read_data);
						if (rsp.status !== want.status)
							report_mismatch("status", 32'(rsp.status), 32'(want.status));
					end
				end
			end
		end
	end

	initial begin
		int unsigned         window_base;
		int unsigned         pick;
		logic [ADDR_W-1:0]   a;
		logic [1:0]          sz;
		arst_n = 1'b0;
		req_valid = 1'b0;
		rsp_ready = 1'b0;
		req = '0;
		req_taken = 1'b0;
		cycle_count = 0;
		req_count = 0;
		rsp_count = 0;
		mismatch_count = 0;
		read_count = 0;
		write_count = 0;
		unaligned_count = 0;
		dropped_count = 0;
		noop_count = 0;
		foreach (mem_image[i])
			mem_image[i] = '0;

		add_access(MODE_WRITE, SIZE_WORD, 12'h000, 32'hffff_ffff);
		add_access(MODE_READ,  SIZE_WORD, 12'h000, 32'h0);
		add_access(MODE_WRITE, SIZE_BYTE, 12'h001, 32'hffff_ff5a);
		add_access(MODE_READ,  SIZE_BYTE, 12'h001, 32'h0);
		add_access(MODE_WRITE, SIZE_HALF, 12'h002, 32'h1234_5678);
		add_access(MODE_READ,  SIZE_HALF, 12'h002, 32'h0);
		add_access(MODE_READ,  SIZE_HALF, 12'h001, 32'h0);
		add_access(MODE_WRITE, SIZE_WORD, 12'h004, 32'h89ab_cdef);
		add_access(MODE_READ,  SIZE_HALF, 12'h003, 32'h0);
		add_access(MODE_WRITE, SIZE_HALF, 12'h001, 32'hffff_ffff);
		add_access(MODE_WRITE, SIZE_HALF, 12'h003, 32'h0000_0000);
		add_access(MODE_READ,  SIZE_WORD, 12'h000, 32'h0);
		add_access(MODE_WRITE, SIZE_WORD, 12'hfff, 32'hdead_beef);
		add_access(MODE_READ,  SIZE_WORD, 12'hfff, 32'h0);
		add_access(MODE_READ,  SIZE_WORD, 12'h001, 32'h0);
		add_access(MODE_READ,  SIZE_WORD, 12'h002, 32'h0);
		add_access(MODE_READ,  SIZE_WORD, 12'h003, 32'h0);
		add_access(MODE_READ,  SIZE_HALF, 12'hfff, 32'h0);
		add_access(MODE_READ,  SIZE_BYTE, 12'hfff, 32'h0);
		add_access(MODE_WRITE, SIZE_NONE, 12'h000, 32'hffff_ffff);
		add_access(MODE_READ,  SIZE_NONE, 12'h008, 32'h0);
		add_access(MODE_READ,  SIZE_WORD, 12'h000, 32'h0);
		add_access(MODE_WRITE, SIZE_BYTE, 12'hfff, 32'h0000_0000);
		add_access(MODE_READ,  SIZE_WORD, 12'hffc, 32'h0);
		add_access(MODE_WRITE, SIZE_WORD, 12'h000, 32'h0000_0000);

		// most accesses hit a small moving window so that reads see earlier writes
		window_base = 0;
		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n % 200 == 0)
				window_base = $urandom_range(4095) & ~32'd31;
			pick = $urandom_range(99);
			if (pick < 70)
				a = ADDR_W'(window_base + $urandom_range(31));
			else if (pick < 90)
				a = ADDR_W'($urandom_range(4095));
			else
				a = ADDR_W'(4088 + $urandom_range(7));
			sz = ($urandom_range(99) < 3) ? SIZE_NONE : 2'($urandom_range(2));
			add_access($urandom_range(1) ? MODE_WRITE : MODE_READ, sz, a, $urandom);
		end

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_req.size() != 0 || req_valid)
			@(negedge clk);
		while (expected_rsp.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		$display("%0d transfers checked: %0d reads, %0d writes, %0d no-access",
			rsp_count, read_count, write_count, noop_count);
		$display("%0d unaligned handled, %0d halfword writes dropped, %0d mismatches",
			unaligned_count, dropped_count, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
